/* src/utf8d_pkg.sv */
package utf8d_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [20:0] CpReplacement = 21'h00FFFD;
  localparam logic [20:0] CpMax         = 21'h10FFFF;
  localparam logic [20:0] SurrogateLo   = 21'h00D800;
  localparam logic [20:0] SurrogateHi   = 21'h00DFFF;

  typedef enum logic [2:0] {
    KIND_CONT = 3'd0,
    KIND_LEN1 = 3'd1,
    KIND_LEN2 = 3'd2,
    KIND_LEN3 = 3'd3,
    KIND_LEN4 = 3'd4,
    KIND_BAD  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_error;
    logic [2:0]  bytes_covered;
    logic        run_end;
  } result_t;

  // One queue entry carries all results caused by one byte.
  typedef struct packed {
    result_t first;
    result_t second;
    logic    has_second;
  } entry_t;

endpackage

/* src/utf8d_front.sv */
module utf8d_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_stream_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output utf8d_pkg::entry_t   push_entry_o
);
  import utf8d_pkg::*;

  logic [20:0] acc_q, acc_d;
  logic [2:0]  exp_len_q, exp_len_d;
  logic [2:0]  seen_q, seen_d;

  kind_e       kind;
  logic        accept;
  logic        pending;
  logic [20:0] acc_ext;
  logic [2:0]  seen_inc;
  result_t     res_a, res_b;
  logic [1:0]  n_res;
  logic        fresh_res;
  result_t     fresh;

  function automatic result_t make_err(input logic [2:0] cov);
    result_t r;
    r.code_point    = CpReplacement;
    r.is_error      = 1'b1;
    r.bytes_covered = cov;
    r.run_end       = 1'b0;
    return r;
  endfunction

  function automatic result_t make_checked(input logic [20:0] val, input logic [2:0] len);
    result_t r;
    logic    bad;
    unique case (len)
      3'd1:    bad = (val > 21'h00007F);
      3'd2:    bad = (val < 21'h000080) || (val > 21'h0007FF);
      3'd3:    bad = (val < 21'h000800) || (val > 21'h00FFFF);
      3'd4:    bad = (val < 21'h010000) || (val > CpMax);
      default: bad = 1'b1;
    endcase
    bad = bad || ((val >= SurrogateLo) && (val <= SurrogateHi));
    r.code_point    = bad ? CpReplacement : val;
    r.is_error      = bad;
    r.bytes_covered = len;
    r.run_end       = 1'b0;
    return r;
  endfunction

  always_comb begin
    if (data_byte_i[7:6] == 2'b10)        kind = KIND_CONT;
    else if (!data_byte_i[7])             kind = KIND_LEN1;
    else if (data_byte_i[7:5] == 3'b110)  kind = KIND_LEN2;
    else if (data_byte_i[7:4] == 4'b1110) kind = KIND_LEN3;
    else if (data_byte_i[7:3] == 5'b11110) kind = KIND_LEN4;
    else                                  kind = KIND_BAD;
  end

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign pending    = (exp_len_q != 3'd0);
  assign acc_ext    = {acc_q[14:0], data_byte_i[5:0]};
  assign seen_inc   = seen_q + 3'd1;

  always_comb begin
    acc_d     = acc_q;
    exp_len_d = exp_len_q;
    seen_d    = seen_q;
    res_a     = make_err(3'd1);
    res_b     = make_err(3'd1);
    n_res     = 2'd0;
    fresh_res = 1'b0;
    fresh     = make_err(3'd1);
    if (pending && kind == KIND_CONT) begin
      acc_d  = acc_ext;
      seen_d = seen_inc;
      if (seen_inc >= exp_len_q) begin
        res_a     = make_checked(acc_ext, exp_len_q);
        n_res     = 2'd1;
        acc_d     = '0;
        exp_len_d = '0;
        seen_d    = '0;
      end else if (end_of_stream_i) begin
        res_a     = make_err(seen_inc);
        n_res     = 2'd1;
        acc_d     = '0;
        exp_len_d = '0;
        seen_d    = '0;
      end
    end else begin
      // Broken prefix first, then handle the byte itself.
      unique case (kind)
        KIND_CONT, KIND_BAD: begin
          fresh_res = 1'b1;
          fresh     = make_err(3'd1);
          acc_d     = '0;
          exp_len_d = '0;
          seen_d    = '0;
        end
        KIND_LEN1: begin
          fresh_res = 1'b1;
          fresh     = make_checked({13'd0, data_byte_i}, 3'd1);
          acc_d     = '0;
          exp_len_d = '0;
          seen_d    = '0;
        end
        KIND_LEN2, KIND_LEN3, KIND_LEN4: begin
          acc_d     = {13'd0, data_byte_i & (8'h7F >> kind)};
          exp_len_d = kind;
          seen_d    = 3'd1;
          if (end_of_stream_i) begin
            fresh_res = 1'b1;
            fresh     = make_err(3'd1);
            acc_d     = '0;
            exp_len_d = '0;
            seen_d    = '0;
          end
        end
        default: begin
          fresh_res = 1'b1;
          fresh     = make_err(3'd1);
        end
      endcase
      if (pending) begin
        res_a = make_err(seen_q);
        res_b = fresh;
        n_res = fresh_res ? 2'd2 : 2'd1;
      end else begin
        res_a = fresh;
        n_res = fresh_res ? 2'd1 : 2'd0;
      end
    end
    if (n_res == 2'd2) res_b.run_end = 1'b1;
    else               res_a.run_end = 1'b1;
  end

  assign push_o                  = accept && (n_res != 2'd0);
  assign push_entry_o.first      = res_a;
  assign push_entry_o.second     = res_b;
  assign push_entry_o.has_second = (n_res == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      exp_len_q <= '0;
      seen_q    <= '0;
    end else if (accept) begin
      acc_q     <= acc_d;
      exp_len_q <= exp_len_d;
      seen_q    <= seen_d;
    end
  end

endmodule

/* src/utf8d_queue.sv */
module utf8d_queue #(
  parameter int unsigned Depth = utf8d_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  utf8d_pkg::entry_t push_entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output utf8d_pkg::entry_t head_o
);
  import utf8d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrW'(1);
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

/* src/utf8d_back.sv */
module utf8d_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  utf8d_pkg::entry_t  head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output utf8d_pkg::result_t out_res_o
);
  import utf8d_pkg::*;

  logic    out_valid_q, out_valid_d;
  result_t out_res_q, out_res_d;
  logic    second_q, second_d;
  logic    load;
  result_t pick;
  logic    last_of_entry;

  assign load          = !out_valid_q || !out_stall_i;
  assign pick          = second_q ? head_i.second : head_i.first;
  assign last_of_entry = second_q || !head_i.has_second;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    second_d    = second_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        out_res_d = pick;
        // advance to the second result or retire the entry
        if (last_of_entry) begin
          pop_o    = 1'b1;
          second_d = 1'b0;
        end else begin
          second_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

/* src/utf8_stream_decoder_unit.sv */
// UTF-8 stream decoder: one byte in, zero to two code points out.
// Input channel: in_valid_i / in_stall_o with data_byte_i and end_of_stream_i;
// a byte transfers at a clock edge where in_valid_i is high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with code_point_o, is_error_o,
// bytes_covered_o and run_end_o; run_end_o marks the last result of a byte.
// The front classifies each byte and updates the partial sequence in the
// cycle of its transfer, pushing its results into a small queue; the back
// drains the queue into an output register, one result per cycle when not stalled.
// Throughput: one byte per cycle on input while in_stall_o is low, one
// result per cycle on output while out_stall_i is low. A byte that breaks
// a pending sequence can yield two results, which leave in turn; the queue
// (QueueDepth entries) absorbs this.
// Stall: with out_stall_i high the output holds; once the queue is full
// in_stall_o rises until the back retires an entry.
// Reset clears the partial sequence, the queue and the output valid.
module utf8_stream_decoder_unit #(
  parameter int unsigned QueueDepth = utf8d_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        is_error_o,
  output logic [2:0]  bytes_covered_o,
  output logic        run_end_o
);
  import utf8d_pkg::*;

  logic    push, full, pop, empty;
  entry_t  push_entry, head;
  result_t out_res;

  utf8d_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .queue_full_i    (full),
    .push_o          (push),
    .push_entry_o    (push_entry)
  );

  utf8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .empty_o      (empty),
    .head_o       (head)
  );

  utf8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign code_point_o    = out_res.code_point;
  assign is_error_o      = out_res.is_error;
  assign bytes_covered_o = out_res.bytes_covered;
  assign run_end_o       = out_res.run_end;

endmodule

/* src/utf8d_checker.sv */
module utf8d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [20:0] code_point_o,
  input logic        is_error_o,
  input logic [2:0]  bytes_covered_o
);
  import utf8d_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_point_o))
    else $error("output changed while stalled");

  a_err_is_fffd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_error_o |-> code_point_o == CpReplacement)
    else $error("error result without replacement character");

  a_cov_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bytes_covered_o >= 3'd1 && bytes_covered_o <= 3'd4)
    else $error("bytes covered out of range");

  a_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_error_o |-> code_point_o <= CpMax &&
      (code_point_o < SurrogateLo || code_point_o > SurrogateHi))
    else $error("decoded value is not a scalar value");

endmodule

bind utf8_stream_decoder_unit utf8d_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .code_point_o    (code_point_o),
  .is_error_o      (is_error_o),
  .bytes_covered_o (bytes_covered_o)
);

/* tb/tb_utf8_stream_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_unit;
  import utf8d_pkg::*;

  typedef enum int {
    STALL_OFF,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        end_of_stream;
  logic        out_valid;
  logic        out_stall;
  logic [20:0] code_point;
  logic        is_error;
  logic [2:0]  bytes_covered;
  logic        run_end;

  // Partial sequence as the decoder should hold it.
  logic [20:0] pend_bits = '0;
  logic [2:0]  pend_len  = '0;
  logic [2:0]  pend_seen = '0;

  result_t     expected_q[$];
  int unsigned fail_count   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned errors_seen  = 0;
  int unsigned dual_bytes   = 0;
  bit          gaps_on      = 1'b1;
  stall_mode_e stall_mode   = STALL_LIGHT;

  always #5 clk = ~clk;

  utf8_stream_decoder_unit DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .end_of_stream_i(end_of_stream),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .code_point_o   (code_point),
    .is_error_o     (is_error),
    .bytes_covered_o(bytes_covered),
    .run_end_o      (run_end)
  );

  function automatic kind_e byte_kind(input logic [7:0] b);
    if (b[7:6] == 2'b10) return KIND_CONT;
    if (!b[7]) return KIND_LEN1;
    if (b[7:5] == 3'b110) return KIND_LEN2;
    if (b[7:4] == 4'b1110) return KIND_LEN3;
    if (b[7:3] == 5'b11110) return KIND_LEN4;
    return KIND_BAD;
  endfunction

  function automatic result_t replaced(input logic [2:0] covered);
    result_t r;
    r.code_point    = CpReplacement;
    r.is_error      = 1'b1;
    r.bytes_covered = covered;
    r.run_end       = 1'b0;
    return r;
  endfunction

  // Range check of a finished sequence: overlong, too large, surrogate.
  function automatic result_t scalar_result(input logic [20:0] value, input logic [2:0] len);
    result_t     r;
    logic [20:0] lo;
    logic [20:0] hi;
    case (len)
      KIND_LEN1: begin lo = 21'h0;     hi = 21'h7F;   end
      KIND_LEN2: begin lo = 21'h80;    hi = 21'h7FF;  end
      KIND_LEN3: begin lo = 21'h800;   hi = 21'hFFFF; end
      default:   begin lo = 21'h10000; hi = CpMax;    end
    endcase
    if (value < lo || value > hi || (value >= SurrogateLo && value <= SurrogateHi))
      return replaced(len);
    r.code_point    = value;
    r.is_error      = 1'b0;
    r.bytes_covered = len;
    r.run_end       = 1'b0;
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic eos);
    kind_e   kind;
    result_t found[2];
    int      n;
    bit      fresh;
    kind  = byte_kind(b);
    n     = 0;
    fresh = 1'b1;
    if (pend_len != 0) begin
      if (kind == KIND_CONT) begin
        fresh     = 1'b0;
        pend_bits = {pend_bits[14:0], b[5:0]};
        pend_seen = pend_seen + 3'd1;
        if (pend_seen >= pend_len) begin
          found[n] = scalar_result(pend_bits, pend_len);
          n++;
          pend_len = '0; pend_seen = '0; pend_bits = '0;
        end else if (eos) begin
          found[n] = replaced(pend_seen);
          n++;
          pend_len = '0; pend_seen = '0; pend_bits = '0;
        end
      end else begin
        // Broken prefix first, then the new byte on its own.
        found[n] = replaced(pend_seen);
        n++;
        pend_len = '0; pend_seen = '0; pend_bits = '0;
      end
    end
    if (fresh) begin
      if (kind == KIND_CONT || kind == KIND_BAD) begin
        found[n] = replaced(3'd1);
        n++;
      end else if (kind == KIND_LEN1) begin
        found[n] = scalar_result({13'd0, b}, KIND_LEN1);
        n++;
      end else begin
        pend_bits = {13'd0, b & (8'h7F >> kind)};
        pend_len  = kind;
        pend_seen = 3'd1;
        if (eos) begin
          found[n] = replaced(3'd1);
          n++;
          pend_len = '0; pend_seen = '0; pend_bits = '0;
        end
      end
    end
    if (n > 0) found[n-1].run_end = 1'b1;
    if (n == 2) dual_bytes++;
    for (int i = 0; i < n; i++) expected_q.push_back(found[i]);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Drive one byte at the falling edge and hold it until the transfer.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    data_byte     = b;
    end_of_stream = eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, eos);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Encode a scalar with a given length and send the first cut bytes.
  task automatic send_scalar(input logic [20:0] cp, input int len, input int cut,
                             input bit eos_last);
    logic [7:0] seq[4];
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < cut; i++) send_byte(seq[i], eos_last && (i == cut - 1));
  endtask

  // Mostly in-range values; now and then raw bits to hit overlong and too large.
  function automatic logic [20:0] random_scalar(input int len);
    logic [20:0] raw;
    raw = 21'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      case (len)
        1: return {14'd0, raw[6:0]};
        2: return {10'd0, raw[10:0]};
        3: return {5'd0, raw[15:0]};
        default: return raw;
      endcase
    end
    case (len)
      1: return 21'($urandom_range(0, 'h7F));
      2: return 21'($urandom_range('h80, 'h7FF));
      3: begin
        if ($urandom_range(0, 15) == 0) return 21'(SurrogateLo + $urandom_range(0, 'h7FF));
        return 21'($urandom_range('h800, 'hFFFF));
      end
      default: return 21'($urandom_range('h10000, CpMax));
    endcase
  endfunction

  task automatic drain();
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    gaps_on    = 1'b1;
    stall_mode = STALL_LIGHT;
    send_byte(8'h00, 1'b0);
    send_scalar(21'h80, 2, 2, 1'b0);
    send_scalar(CpReplacement, 3, 3, 1'b0);
    send_scalar(CpMax, 4, 4, 1'b0);
    send_scalar(21'h0, 2, 2, 1'b0);          // overlong
    send_scalar(21'h110000, 4, 4, 1'b0);     // too large
    send_scalar(SurrogateLo, 3, 3, 1'b0);    // surrogate
    send_byte(8'h80, 1'b0);                  // stray continuation
    send_byte(8'hFF, 1'b0);                  // invalid lead
    send_scalar(21'h20AC, 3, 1, 1'b0);
    send_byte(8'h41, 1'b0);                  // breaks the pending sequence
    send_scalar(21'h20AC, 3, 2, 1'b1);       // cut short by end of stream
    send_byte(8'hF0, 1'b1);                  // lead on the final byte
    send_byte(8'h41, 1'b1);
    drain();
  endtask

  task automatic test_wellformed(input int count);
    int len;
    gaps_on    = 1'b1;
    stall_mode = STALL_LIGHT;
    repeat (count) begin
      len = $urandom_range(1, 4);
      send_scalar(random_scalar(len), len, len, $urandom_range(0, 9) == 0);
    end
    drain();
  endtask

  task automatic test_broken(input int count);
    int unsigned r;
    int          len;
    logic [7:0]  noise;
    gaps_on    = 1'b1;
    stall_mode = STALL_LIGHT;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        noise = 8'($urandom);
        send_byte(noise, $urandom_range(0, 15) == 0);
      end else if (r < 70) begin
        len = $urandom_range(2, 4);
        send_scalar(random_scalar(len), len, $urandom_range(1, len - 1),
                    $urandom_range(0, 1) == 1);
      end else begin
        len = $urandom_range(1, 4);
        send_scalar(random_scalar(len), len, len, 1'b0);
      end
    end
    drain();
  endtask

  task automatic test_back_to_back(input int count);
    int         len;
    logic [7:0] noise;
    gaps_on    = 1'b0;
    stall_mode = STALL_OFF;
    repeat (count) begin
      len = $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) begin
        noise = 8'($urandom);
        send_byte(noise, 1'b0);
      end else begin
        send_scalar(random_scalar(len), len, len, 1'b0);
      end
    end
    drain();
  endtask

  // Broken three-byte sequences against a mostly stalled sink fill the queue.
  task automatic test_backpressure(input int count);
    gaps_on    = 1'b0;
    stall_mode = STALL_HEAVY;
    repeat (count) begin
      send_byte(8'hE2, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h80 | 8'($urandom_range(0, 'h3F)), 1'b0);
    end
    stall_mode = STALL_LIGHT;
    drain();
  endtask

  initial begin
    int unsigned hold;
    int unsigned r;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_mode == STALL_OFF) begin
        out_stall = 1'b0;
        hold      = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (stall_mode == STALL_HEAVY) begin
          out_stall = (r < 80);
          hold      = out_stall ? $urandom_range(2, 12) : $urandom_range(0, 1);
        end else if (r < 75) begin
          out_stall = 1'b0;
          hold      = $urandom_range(0, 6);
        end else if (r < 95) begin
          out_stall = 1'b1;
          hold      = $urandom_range(0, 2);
        end else begin
          out_stall = 1'b1;
          hold      = $urandom_range(5, 30);
        end
      end
    end
  end

  task automatic compare_field(input string name, input logic [20:0] want,
                               input logic [20:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual cp=%0h err=%b cov=%0d end=%b",
                 $time, code_point, is_error, bytes_covered, run_end);
      end else begin
        want = expected_q.pop_front();
        results_seen++;
        if (want.is_error) errors_seen++;
        compare_field("code_point", want.code_point, code_point);
        compare_field("is_error", 21'(want.is_error), 21'(is_error));
        compare_field("bytes_covered", 21'(want.bytes_covered), 21'(bytes_covered));
        compare_field("run_end", 21'(want.run_end), 21'(run_end));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    data_byte     = 8'h00;
    end_of_stream = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_wellformed(140);
    test_broken(120);
    test_back_to_back(40);
    test_backpressure(20);

    if (expected_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results expected but never seen", $time, expected_q.size());
    end
    $display("Sent %0d bytes, checked %0d code points (%0d replacements).",
             bytes_sent, results_seen, errors_seen);
    $display("Bytes with two results: %0d; mismatches: %0d.", dual_bytes, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
